@@ sv/mstc_pkg.sv @@
// Shared types and constants for the money string to cents parser.
package mstc_pkg;

  localparam int WHOLE_W = 31;
  localparam int FRAC_W  = 8;
  localparam int CHAR_W  = 8;
  localparam int NIB_W   = 4;
  localparam int STAT_W  = 3;

  localparam logic [CHAR_W-1:0]  CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  NIB_MASK   = 8'h0F;
  localparam logic [1:0]         FRAC_SAT   = 2'd3;
  localparam logic [1:0]         CHARS_SAT  = 2'd2;
  localparam logic [WHOLE_W-1:0] MAX31      = 31'h7FFF_FFFF;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_LEADING_ZERO = 3'd1,
    ST_FRACTION_LONG = 3'd2,
    ST_SECOND_POINT = 3'd3,
    ST_OVERFLOW     = 3'd4
  } status_t;

  // Parser state; also the snapshot handed to the result stage.
  typedef struct packed {
    logic [WHOLE_W-1:0] whole_accum;
    logic               point_seen;
    logic [1:0]         fraction_count;
    logic [FRAC_W-1:0]  fraction_value;
    logic [1:0]         chars_seen;
    logic               first_is_zero;
    logic               leading_zero_error;
    logic               second_point_error;
    logic               overflow_flag;
  } parse_state_t;

endpackage

@@ sv/mstc_if.sv @@
// Valid/ready channel interfaces for characters in and results out.
interface mstc_in_if;
  logic                        valid;
  logic                        ready;
  logic [mstc_pkg::CHAR_W-1:0] char_code;
  logic                        is_last;

  modport source(output valid, output char_code, output is_last, input ready);
  modport sink(input valid, input char_code, input is_last, output ready);
endinterface

interface mstc_out_if;
  logic                         valid;
  logic                         ready;
  logic [mstc_pkg::WHOLE_W-1:0] cents;
  logic [mstc_pkg::STAT_W-1:0]  status;

  modport source(output valid, output cents, output status, input ready);
  modport sink(input valid, input cents, input status, output ready);
endinterface

@@ sv/mstc_step.sv @@
// Per-character parser state update and end-of-amount snapshot register.
module mstc_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        load_en,
  input  logic [mstc_pkg::CHAR_W-1:0] char_code,
  input  logic                        is_last,
  output logic                        snap_valid,
  output mstc_pkg::parse_state_t      snap
);

  localparam int WIDE_W = mstc_pkg::WHOLE_W + mstc_pkg::NIB_W;

  mstc_pkg::parse_state_t st;
  mstc_pkg::parse_state_t st_next;

  logic [mstc_pkg::NIB_W-1:0] nib;
  logic                       is_point;
  logic [WIDE_W-1:0]          whole_wide;

  assign nib      = mstc_pkg::NIB_W'(char_code & mstc_pkg::NIB_MASK);
  assign is_point = (char_code == mstc_pkg::CHAR_POINT);
  assign whole_wide = WIDE_W'(st.whole_accum) * WIDE_W'(10) + WIDE_W'(nib);

  always_comb begin
    st_next = st;
    case (st.chars_seen)
      2'd0: begin
        st_next.first_is_zero = (char_code == mstc_pkg::CHAR_ZERO);
      end
      2'd1: begin
        if (st.first_is_zero && !is_point) begin
          st_next.leading_zero_error = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (st.chars_seen != mstc_pkg::CHARS_SAT) begin
      st_next.chars_seen = st.chars_seen + 2'd1;
    end

    if (st.point_seen) begin
      if (is_point) begin
        st_next.second_point_error = 1'b1;
      end
      case (st.fraction_count)
        2'd0: st_next.fraction_value = mstc_pkg::FRAC_W'(nib) * mstc_pkg::FRAC_W'(10);
        2'd1: st_next.fraction_value = st.fraction_value + mstc_pkg::FRAC_W'(nib);
        default: begin
        end
      endcase
      if (st.fraction_count != mstc_pkg::FRAC_SAT) begin
        st_next.fraction_count = st.fraction_count + 2'd1;
      end
    end else if (is_point) begin
      st_next.point_seen = 1'b1;
    end else if (whole_wide[WIDE_W-1:mstc_pkg::WHOLE_W] != '0) begin
      // clamp instead of wrapping
      st_next.overflow_flag = 1'b1;
      st_next.whole_accum   = mstc_pkg::MAX31;
    end else begin
      st_next.whole_accum = whole_wide[mstc_pkg::WHOLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= is_last ? '0 : st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (load_en) begin
      snap_valid <= accept && is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && accept && is_last) begin
      snap <= st_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && is_last |=> st.chars_seen == 2'd0 && !st.point_seen && !st.overflow_flag)
    else $error("parser state not cleared after last character");

  a_clamp_held: assert property (@(posedge clk) disable iff (rst)
    st.overflow_flag |-> st.whole_accum == mstc_pkg::MAX31)
    else $error("overflowed accumulator not clamped");

  a_fraction_after_point: assert property (@(posedge clk) disable iff (rst)
    st.fraction_count != 2'd0 |-> st.point_seen)
    else $error("fraction characters counted without a point");
`endif

endmodule

@@ sv/mstc_compose.sv @@
// Result stage: scales the snapshot to cents, picks the status, holds the result.
module mstc_compose (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         snap_valid,
  input  mstc_pkg::parse_state_t       snap,
  output logic                         res_valid,
  output logic [mstc_pkg::WHOLE_W-1:0] cents,
  output logic [mstc_pkg::STAT_W-1:0]  status
);

  localparam int TOT_W = mstc_pkg::WHOLE_W + 7;

  logic [TOT_W-1:0]            total;
  mstc_pkg::status_t           stat_next;
  logic [mstc_pkg::WHOLE_W-1:0] cents_next;

  assign total = TOT_W'(snap.whole_accum) * TOT_W'(100) + TOT_W'(snap.fraction_value);

  always_comb begin
    cents_next = '0;
    if (snap.leading_zero_error) begin
      stat_next = mstc_pkg::ST_LEADING_ZERO;
    end else if (snap.fraction_count == mstc_pkg::FRAC_SAT) begin
      stat_next = mstc_pkg::ST_FRACTION_LONG;
    end else if (snap.second_point_error) begin
      stat_next = mstc_pkg::ST_SECOND_POINT;
    end else if (snap.overflow_flag || total[TOT_W-1:mstc_pkg::WHOLE_W] != '0) begin
      stat_next = mstc_pkg::ST_OVERFLOW;
    end else begin
      stat_next  = mstc_pkg::ST_OK;
      cents_next = total[mstc_pkg::WHOLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && snap_valid) begin
      cents  <= cents_next;
      status <= stat_next;
    end
  end

endmodule

@@ sv/money_string_to_cents.sv @@
// Money amount parser: one ASCII character per transfer in, cents and status out.
// Throughput: one character per cycle, with no gaps while ready stays high.
// Result path after the transfer of the last character: the snapshot register,
// then the x100 scaling into the result register.
// A pending snapshot lets input continue while a result waits; ready drops only
// when both the snapshot and the result register are full and the sink stalls.
// Reset: synchronous, clears parser state and both valid flags.
module money_string_to_cents (
  input  logic       clk,
  input  logic       rst,
  mstc_in_if.sink    in_ch,
  mstc_out_if.source out_ch
);

  logic                   advance;
  logic                   load_en;
  logic                   accept;
  logic                   snap_valid;
  mstc_pkg::parse_state_t snap;

  assign advance     = !out_ch.valid || out_ch.ready;
  assign load_en     = advance || !snap_valid;
  assign in_ch.ready = load_en;
  assign accept      = in_ch.valid && in_ch.ready;

  mstc_step u_step (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .load_en    (load_en),
    .char_code  (in_ch.char_code),
    .is_last    (in_ch.is_last),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  mstc_compose u_compose (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .snap_valid (snap_valid),
    .snap       (snap),
    .res_valid  (out_ch.valid),
    .cents      (out_ch.cents),
    .status     (out_ch.status)
  );

`ifndef NO_ASSERTIONS
  a_cents_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != mstc_pkg::ST_OK |-> out_ch.cents == '0)
    else $error("nonzero cents with error status");

  a_snap_kept: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !advance |=> snap_valid)
    else $error("pending snapshot dropped");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> snap_valid && out_ch.valid && !out_ch.ready)
    else $error("input stalled without a full pipeline");
`endif

endmodule

@@ tb/sv/money_string_to_cents_chk.sv @@
// Checker for the money string parser: predicts each amount's result and compares.
module money_string_to_cents_chk
  import mstc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mstc_in_if   in_ch,
  mstc_out_if  out_ch,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   ok_seen
);

  typedef struct {
    logic [WHOLE_W-1:0] cents;
    status_t            status;
  } amount_result_t;

  amount_result_t due_q[$];

  // predicted parser state
  logic [31:0]       whole;
  logic              saw_point;
  logic [1:0]        frac_n;
  logic [FRAC_W-1:0] frac_val;
  logic [1:0]        n_chars;
  logic              zero_first;
  logic              lz_err;
  logic              dup_point;
  logic              ovf;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
    ok_seen = 0;
  end

  task automatic clear_parser();
    whole      = '0;
    saw_point  = 1'b0;
    frac_n     = '0;
    frac_val   = '0;
    n_chars    = '0;
    zero_first = 1'b0;
    lz_err     = 1'b0;
    dup_point  = 1'b0;
    ovf        = 1'b0;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    if (errors < 40)
      $display("ERROR: result %0d: %s got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  task automatic take_char(input logic [CHAR_W-1:0] c, input logic last);
    logic [NIB_W-1:0] nib;
    logic [63:0]      grown;
    amount_result_t   res;
    nib = c[NIB_W-1:0];
    if (n_chars == 2'd0)
      zero_first = (c == CHAR_ZERO);
    else if (n_chars == 2'd1 && zero_first && c != CHAR_POINT)
      lz_err = 1'b1;
    if (n_chars < CHARS_SAT)
      n_chars = n_chars + 1'b1;

    if (saw_point) begin
      if (c == CHAR_POINT)
        dup_point = 1'b1;
      if (frac_n == 2'd0)
        frac_val = 8'(nib) * 8'd10;
      else if (frac_n == 2'd1)
        frac_val = frac_val + 8'(nib);
      if (frac_n < FRAC_SAT)
        frac_n = frac_n + 1'b1;
    end else if (c == CHAR_POINT) begin
      saw_point = 1'b1;
    end else begin
      // clamp instead of wrapping; the flag remembers it
      grown = 64'(whole) * 64'd10 + 64'(nib);
      if (grown > 64'(MAX31)) begin
        ovf   = 1'b1;
        whole = 32'(MAX31);
      end else begin
        whole = grown[31:0];
      end
    end

    if (last) begin
      grown     = 64'(whole) * 64'd100 + 64'(frac_val);
      res.cents = '0;
      if (lz_err)
        res.status = ST_LEADING_ZERO;
      else if (frac_n == FRAC_SAT)
        res.status = ST_FRACTION_LONG;
      else if (dup_point)
        res.status = ST_SECOND_POINT;
      else if (ovf || grown > 64'(MAX31))
        res.status = ST_OVERFLOW;
      else begin
        res.status = ST_OK;
        res.cents  = grown[WHOLE_W-1:0];
      end
      due_q.push_back(res);
      clear_parser();
    end
  endtask

  always @(posedge clk) begin
    amount_result_t want;
    if (rst) begin
      clear_parser();
      due_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        take_char(in_ch.char_code, in_ch.is_last);
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          report("result with no amount pending, cents", out_ch.cents, 0);
        end else begin
          want = due_q.pop_front();
          if (out_ch.cents !== want.cents)
            report("cents", out_ch.cents, want.cents);
          if (out_ch.status !== want.status)
            report("status", out_ch.status, want.status);
          if (want.status == ST_OK)
            ok_seen++;
        end
        checked++;
      end
    end
    pending = due_q.size();
  end

endmodule

@@ tb/sv/money_string_to_cents_tb.sv @@
// Testbench top for the money string parser: clock, reset, stimulus and verdict.
module money_string_to_cents_tb;
  import mstc_pkg::*;

  localparam int ITEM_GOAL   = 1450;
  localparam int MAX_GAP     = 17;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_item_t;

  logic clk;
  logic rst;
  logic hold_sink;

  mstc_in_if  in_ch();
  mstc_out_if out_ch();

  char_item_t feed_q[$];
  int amounts;
  int sent;
  int cycles;
  int errors;
  int pending;
  int checked;
  int ok_seen;

  money_string_to_cents DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  money_string_to_cents_chk u_chk (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending),
    .checked (checked),
    .ok_seen (ok_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void queue_amount(input logic [CHAR_W-1:0] q[$]);
    foreach (q[i])
      feed_q.push_back('{code: q[i], last: (i == q.size() - 1)});
    amounts++;
  endfunction

  function automatic void queue_text(input string s);
    logic [CHAR_W-1:0] q[$];
    foreach (s[i])
      q.push_back(s[i]);
    queue_amount(q);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_digit(input bit nonzero);
    return CHAR_ZERO + 8'($urandom_range(nonzero ? 1 : 0, 9));
  endfunction

  function automatic void gen_amount();
    logic [CHAR_W-1:0] q[$];
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      // well-formed amount, optionally broken afterwards
      if ($urandom_range(0, 19) == 0) begin
        q = '{"2", "1", "4", "7", "4", "8", "3", "6"};
      end else if ($urandom_range(0, 9) == 0) begin
        q.push_back(CHAR_ZERO);
      end else if ($urandom_range(0, 19) != 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
        q.push_back(rand_digit(1'b1));
        repeat (n - 1) q.push_back(rand_digit(1'b0));
      end
      if (q.size() == 0 || $urandom_range(0, 2) != 0) begin
        q.push_back(CHAR_POINT);
        repeat ($urandom_range(0, 2)) q.push_back(rand_digit(1'b0));
      end
      if (r >= 70) begin
        case ($urandom_range(0, 2))
          0: q.push_front(CHAR_ZERO);
          1: begin
            q.push_back(CHAR_POINT);
            repeat ($urandom_range(1, 4)) q.push_back(rand_digit(1'b0));
          end
          default: q.insert($urandom_range(0, q.size()), CHAR_POINT);
        endcase
      end
    end else begin
      // arbitrary bytes, biased toward the characters the parser cares about
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 7))
          0, 1:    q.push_back(CHAR_POINT);
          2:       q.push_back(CHAR_ZERO);
          default: q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    queue_amount(q);
  endfunction

  // stimulus, end of run and verdict
  initial begin
    int gap;
    bit busy;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= '0;
    in_ch.is_last   <= 1'b0;
    amounts = 0;
    sent    = 0;
    busy    = 1'b0;

    queue_text("0");
    queue_text("0.5");
    queue_text("05");
    queue_text("0.");
    queue_text("00.123");
    queue_text("0..");
    queue_text("12.34");
    queue_text("7.5");
    queue_text(".");
    queue_text(".05");
    queue_text("12.345");
    queue_text("1.2.3");
    queue_text("1..");
    queue_text("1.2.");
    queue_text("21474836.47");
    queue_text("21474836.48");
    queue_text("2147483647");
    queue_text("99999999999");
    queue_text("?.??");
    queue_text("abc");
    queue_amount('{8'h00});
    queue_amount('{8'hFF});
    queue_amount('{8'h80, 8'h7F, CHAR_POINT, 8'hF9});
    while (feed_q.size() < ITEM_GOAL)
      gen_amount();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < feed_q.size(); i++) begin
      if (i % 50 == 0)
        busy = ($urandom_range(0, 3) == 0);
      gap = (busy || hold_sink) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.char_code <= feed_q[i].code;
      in_ch.is_last   <= feed_q[i].last;
      do @(posedge clk); while (!in_ch.ready);
      sent++;
    end
    in_ch.valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d characters in %0d amounts; %0d results checked, %0d of them ok.",
             sent, amounts, checked, ok_seen);
    $display("Receiver held off once for %0d cycles; run took %0d cycles.",
             HOLD_CYCLES, cycles);
    if (errors == 0)
      $display("money_string_to_cents: match");
    else
      $display("money_string_to_cents: mismatch");
    $finish;
  end

  // result side: random stalls after each transfer, plus the long hold-off
  initial begin
    int stall;
    int taken;
    bit busy;
    out_ch.ready <= 1'b0;
    stall = 0;
    taken = 0;
    busy  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        taken++;
        if (taken % 40 == 0)
          busy = ($urandom_range(0, 3) == 0);
        stall = busy ? 0 : $urandom_range(0, MAX_GAP);
      end else if (stall > 0) begin
        stall--;
      end
      out_ch.ready <= (stall == 0) && !hold_sink;
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    hold_sink <= 1'b0;
    while (sent < HOLD_AFTER) @(posedge clk);
    hold_sink <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_sink <= 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
    $display("money_string_to_cents: mismatch");
    $finish;
  end

endmodule
